// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pev_pkg.sv =====
package pev_pkg;

  localparam int MaxBoxesDefault  = 64;
  localparam int CoordBitsDefault = 10;
  localparam int VolBits          = 30;
  localparam int CapBits          = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_POINT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SPAWN_RIGHT = 2'd0,
    SPAWN_TOP   = 2'd1,
    SPAWN_FRONT = 2'd2,
    SPAWN_NONE  = 2'd3
  } spawn_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL1,
    ST_MUL2,
    ST_DONE,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic do_clear;
    logic do_add;
    logic do_load;
    logic scan_start;
    logic scan_step;
    logic scan_last;
    logic drain;
    logic mul1;
    logic mul2;
    logic finish;
  } pev_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic table_empty;
    logic last_entry;
  } pev_stat_t;

endpackage

// ===== hw/rtl/pev_ram.sv =====
module pev_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pev_ctrl.sv =====
module pev_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  output logic              out_valid,
  input  logic              out_ready,
  input  pev_pkg::pev_stat_t stat,
  output pev_pkg::pev_cmd_t  cmd
);

  pev_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pev_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      pev_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (pev_pkg::cmd_t'(in_command))
            pev_pkg::CMD_CLEAR: begin
              cmd.do_clear = 1'b1;
              state_nxt    = pev_pkg::ST_OUT;
            end
            pev_pkg::CMD_ADD: begin
              cmd.do_add = 1'b1;
              state_nxt  = pev_pkg::ST_OUT;
            end
            pev_pkg::CMD_LOAD: begin
              cmd.do_load = 1'b1;
              state_nxt   = pev_pkg::ST_OUT;
            end
            default: begin
              cmd.scan_start = 1'b1;
              state_nxt = stat.table_empty ? pev_pkg::ST_MUL1 : pev_pkg::ST_SCAN;
            end
          endcase
        end
      end
      pev_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.last_entry) begin
          cmd.scan_last = 1'b1;
          state_nxt     = pev_pkg::ST_DRAIN;
        end
      end
      pev_pkg::ST_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = pev_pkg::ST_MUL1;
      end
      pev_pkg::ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = pev_pkg::ST_MUL2;
      end
      pev_pkg::ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = pev_pkg::ST_DONE;
      end
      pev_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = pev_pkg::ST_OUT;
      end
      pev_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = pev_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pev_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/pev_dp.sv =====
module pev_dp #(
  parameter int MaxBoxes  = pev_pkg::MaxBoxesDefault,
  parameter int CoordBits = pev_pkg::CoordBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pev_pkg::pev_cmd_t             cmd,
  output pev_pkg::pev_stat_t            stat,
  input  logic [CoordBits-1:0]          in_pos_x,
  input  logic [CoordBits-1:0]          in_pos_y,
  input  logic [CoordBits-1:0]          in_pos_z,
  input  logic [CoordBits-1:0]          in_size_x,
  input  logic [CoordBits-1:0]          in_size_y,
  input  logic [CoordBits-1:0]          in_size_z,
  input  logic [1:0]                    in_spawn_kind,
  input  logic [pev_pkg::VolBits-1:0]   in_capacity_value,
  output logic [pev_pkg::VolBits-1:0]   out_excluded_volume,
  output logic signed [pev_pkg::CapBits-1:0] out_remaining_capacity,
  output logic                          out_table_full
);

  localparam int AW  = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int CW  = $clog2(MaxBoxes + 1);
  localparam int EW  = 6 * CoordBits;
  localparam int SW  = CoordBits + 1;
  localparam int PW  = 2 * SW;
  localparam int VB  = pev_pkg::VolBits;
  localparam int CB  = pev_pkg::CapBits;

  typedef logic [CoordBits-1:0] crd_t;

  typedef struct packed {
    logic valid;
    crd_t x0, y0, z0, xl, yl, zl;
  } hit_t;

  // Counters, point and results.
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          rvalid_r;
  crd_t px_r, py_r, pz_r, fw_r, fh_r, fd_r;
  logic [1:0] kind_r;
  hit_t lex_r, lsp_r, bex_r, bsp_r, bel_r;
  logic [SW-1:0] vx_r, vy_r, vz_r;
  logic          zero_r;
  logic [PW-1:0] pxy_r;
  logic [VB-1:0] vol_r;
  logic [CB-1:0] cap_r;
  logic          full_r;

  logic [EW-1:0] rdata;
  logic          we;
  crd_t bx0, by0, bz0, bxl, byl, bzl;
  logic [SW-1:0] ex, ey, ez;

  assign we = cmd.do_add && (count_r < CW'(MaxBoxes));

  pev_ram #(.Width(EW), .Depth(MaxBoxes)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count_r[AW-1:0]),
    .wdata({in_pos_x, in_pos_y, in_pos_z, in_size_x, in_size_y, in_size_z}),
    .raddr(idx_nxt),
    .rdata(rdata)
  );

  assign {bx0, by0, bz0, bxl, byl, bzl} = rdata;
  assign ex = SW'(bx0) + SW'(bxl);
  assign ey = SW'(by0) + SW'(byl);
  assign ez = SW'(bz0) + SW'(bzl);

  assign stat.table_empty = (count_r == '0);
  assign stat.last_entry  = (CW'(idx_r) == count_r - CW'(1));

  // Scan address: zero at start, steps while scanning.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.scan_start) begin
      idx_nxt = '0;
    end else if (cmd.scan_step && !cmd.scan_last) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  // Matching on the entry that the RAM presents.
  logic m_lex, m_lsp, m_bex, m_bsp, m_bel;
  logic in_py, in_pz, in_px;
  hit_t cur;
  always_comb begin
    in_px = (SW'(px_r) >= SW'(bx0)) && (SW'(px_r) < ex);
    in_py = (SW'(py_r) >= SW'(by0)) && (SW'(py_r) < ey);
    in_pz = (SW'(pz_r) >= SW'(bz0)) && (SW'(pz_r) < ez);
    m_lex = (ex == SW'(px_r)) && (by0 == py_r) && (bz0 == pz_r);
    m_lsp = (ex == SW'(px_r)) && in_py && in_pz;
    m_bex = (ez == SW'(pz_r)) && (bx0 == px_r) && (by0 == py_r);
    m_bsp = (ez == SW'(pz_r)) && in_px && in_py;
    m_bel = (ey == SW'(py_r)) && (bx0 == px_r) && (bz0 == pz_r);
    cur   = {1'b1, bx0, by0, bz0, bxl, byl, bzl};
  end

  // Extents from the found boxes.
  logic [SW-1:0] nx, ny, nz, t1, t2;
  logic          nzero;
  always_comb begin
    nx = '0; ny = '0; nz = '0; nzero = 1'b1;
    t1 = SW'(bsp_r.y0) + SW'(bsp_r.yl) - SW'(py_r);
    t2 = SW'(lsp_r.y0) + SW'(lsp_r.yl) - SW'(py_r);
    case (pev_pkg::spawn_t'(kind_r))
      pev_pkg::SPAWN_RIGHT: begin
        nz = SW'(lex_r.zl);
        if (bsp_r.valid) nx = SW'(bsp_r.x0) + SW'(bsp_r.xl) - SW'(px_r);
        else nx = SW'(fw_r);
        ny = (bsp_r.valid && bsp_r.yl < lex_r.yl) ? SW'(bsp_r.yl) : SW'(lex_r.yl);
        nzero = !lex_r.valid || (!bsp_r.valid && pz_r != '0);
      end
      pev_pkg::SPAWN_TOP: begin
        nx = SW'(bel_r.xl);
        if (bsp_r.valid && (SW'(bsp_r.x0) + SW'(bsp_r.xl) - SW'(px_r)) < nx)
          nx = SW'(bsp_r.x0) + SW'(bsp_r.xl) - SW'(px_r);
        nz = SW'(bel_r.zl);
        if (lsp_r.valid && (SW'(lsp_r.z0) + SW'(lsp_r.zl) - SW'(pz_r)) < nz)
          nz = SW'(lsp_r.z0) + SW'(lsp_r.zl) - SW'(pz_r);
        if (bsp_r.valid && lsp_r.valid) ny = (t1 < t2) ? t1 : t2;
        else if (bsp_r.valid) ny = t1;
        else if (lsp_r.valid) ny = t2;
        else ny = SW'(fh_r);
        nzero = !bel_r.valid || (!bsp_r.valid && pz_r != '0) ||
                (!lsp_r.valid && px_r != '0);
      end
      pev_pkg::SPAWN_FRONT: begin
        nx = SW'(bex_r.xl);
        if (lsp_r.valid) nz = SW'(lsp_r.z0) + SW'(lsp_r.zl) - SW'(pz_r);
        else nz = SW'(fd_r);
        ny = (lsp_r.valid && lsp_r.yl < bex_r.yl) ? SW'(lsp_r.yl) : SW'(bex_r.yl);
        nzero = !bex_r.valid || (!lsp_r.valid && px_r != '0);
      end
      default: nzero = 1'b1;
    endcase
  end

  logic [PW+SW-1:0] prod;
  assign prod = pxy_r * vz_r;

  // Volume of this point, cut to the result width.
  logic [VB-1:0] vol_nxt;
  assign vol_nxt = zero_r ? '0 : VB'(prod);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cap_r    <= '0;
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= cmd.scan_start ? !stat.table_empty : (cmd.scan_step && !cmd.scan_last);
      if (cmd.do_clear) count_r <= '0;
      else if (we) count_r <= count_r + CW'(1);
      if (cmd.do_load) cap_r <= CB'(in_capacity_value);
      else if (cmd.finish) cap_r <= cap_r - CB'(vol_nxt);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.capture) begin
      px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
      fw_r <= in_size_x; fh_r <= in_size_y; fd_r <= in_size_z;
      kind_r <= in_spawn_kind;
      full_r <= cmd.do_add && !we;
      vol_r  <= '0;
      lex_r <= '0; lsp_r <= '0; bex_r <= '0; bsp_r <= '0; bel_r <= '0;
    end else if (rvalid_r) begin
      if (m_lex) lex_r <= cur;
      if (m_lsp) lsp_r <= cur;
      if (m_bex) bex_r <= cur;
      if (m_bsp) bsp_r <= cur;
      if (m_bel) bel_r <= cur;
    end
    if (cmd.mul1) begin
      vx_r <= nx; vy_r <= ny; vz_r <= nz; zero_r <= nzero;
    end
    if (cmd.mul2) pxy_r <= vx_r * vy_r;
    if (cmd.finish) vol_r <= vol_nxt;
  end

  assign out_excluded_volume    = vol_r;
  assign out_remaining_capacity = cap_r;
  assign out_table_full         = full_r;

endmodule

// ===== hw/rtl/packing_excluded_volume_estimator_top.sv =====
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | command, pos xyz, size xyz, spawn kind, capacity
// out     | out_valid / out_ready  | excluded_volume, remaining_capacity, table_full
//
// Clear, add and load offer their result in the cycle after they are taken.
// A point first scans the table with one RAM read per stored box, then runs
// the extent, multiply and subtract steps before its result is offered; an
// empty table skips the scan.
// Reset (rst_n low, synchronous) empties the table and zeroes the capacity.
// A new beat is taken only after the previous result leaves.
module packing_excluded_volume_estimator_top #(
  parameter int MaxBoxes  = pev_pkg::MaxBoxesDefault,
  parameter int CoordBits = pev_pkg::CoordBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [CoordBits-1:0] in_pos_x,
  input  logic [CoordBits-1:0] in_pos_y,
  input  logic [CoordBits-1:0] in_pos_z,
  input  logic [CoordBits-1:0] in_size_x,
  input  logic [CoordBits-1:0] in_size_y,
  input  logic [CoordBits-1:0] in_size_z,
  input  logic [1:0]           in_spawn_kind,
  input  logic [29:0]          in_capacity_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [29:0]          out_excluded_volume,
  output logic signed [31:0]   out_remaining_capacity,
  output logic                 out_table_full
);

  pev_pkg::pev_cmd_t  cmd;
  pev_pkg::pev_stat_t stat;

  pev_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  pev_dp #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_size_x(in_size_x), .in_size_y(in_size_y), .in_size_z(in_size_z),
    .in_spawn_kind(in_spawn_kind), .in_capacity_value(in_capacity_value),
    .out_excluded_volume(out_excluded_volume),
    .out_remaining_capacity(out_remaining_capacity),
    .out_table_full(out_table_full)
  );

endmodule

// ===== hw/rtl/pev_checker.sv =====
`include "assert_macros.svh"

module pev_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [29:0] out_excluded_volume,
  input logic        out_table_full
);

  // One item at a time: no new beat while a result is offered.
  `CHK_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken during output")
  // A held result stays put.
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  // Non-point commands report zero volume.
  `CHK_NEXT(a_zero_vol, clk, rst_n, in_valid && in_ready && in_command != pev_pkg::CMD_POINT,
            out_valid && out_excluded_volume == '0, "nonzero volume")
  // Only adds can flag a full table.
  `CHK_NEXT(a_full_add, clk, rst_n, in_valid && in_ready && in_command != pev_pkg::CMD_ADD,
            !out_table_full, "spurious full flag")

endmodule

bind packing_excluded_volume_estimator_top pev_checker u_pev_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_command(in_command), .out_valid(out_valid), .out_ready(out_ready),
  .out_excluded_volume(out_excluded_volume), .out_table_full(out_table_full)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int BoxLimit = 64;
  localparam int StallLimit = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = pev_pkg::CMD_CLEAR;
  logic [9:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [9:0] in_size_x = '0, in_size_y = '0, in_size_z = '0;
  logic [1:0] in_spawn_kind = pev_pkg::SPAWN_NONE;
  logic [29:0] in_capacity_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [29:0] out_excluded_volume;
  logic signed [31:0] out_remaining_capacity;
  logic out_table_full;

  typedef struct {
    logic [29:0] vol;
    logic [31:0] cap;
    logic full;
  } outcome_t;

  typedef struct {
    int unsigned x0, y0, z0, xl, yl, zl;
  } placed_box_t;

  placed_box_t boxes[BoxLimit];
  int unsigned box_total;
  logic [31:0] free_cap;
  outcome_t pending[$];
  int errors;
  int idle_cycles;
  bit timed_out;
  int unsigned burst_left;

  packing_excluded_volume_estimator_top uut (.*);

  always #4 clk = ~clk;

  // Receiver stalls in runs of its own.
  int unsigned stall_mode;
  always @(posedge clk) begin
    if ($urandom_range(0, 99) < 3) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_excluded_volume !== e.vol) begin
          $error("excluded_volume expected %0d actual %0d", e.vol, out_excluded_volume);
          errors++;
        end
        if (out_remaining_capacity !== e.cap) begin
          $error("remaining_capacity expected %0d actual %0d", $signed(e.cap),
                 out_remaining_capacity);
          errors++;
        end
        if (out_table_full !== e.full) begin
          $error("table_full expected %0d actual %0d", e.full, out_table_full);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit spans(int unsigned v, int unsigned lo, int unsigned len);
    return lo <= v && v < lo + len;
  endfunction

  // Last box in table order that touches the point in the given way.
  // Way: 0 left exact, 1 left span, 2 behind exact, 3 behind span, 4 below exact.
  function automatic int find_box(int way, int unsigned px, int unsigned py,
                                  int unsigned pz);
    int hit;
    bit m;
    placed_box_t b;
    hit = -1;
    for (int i = 0; i < box_total; i++) begin
      b = boxes[i];
      case (way)
        0: m = b.x0 + b.xl == px && b.y0 == py && b.z0 == pz;
        1: m = b.x0 + b.xl == px && spans(py, b.y0, b.yl) && spans(pz, b.z0, b.zl);
        2: m = b.z0 + b.zl == pz && b.x0 == px && b.y0 == py;
        3: m = b.z0 + b.zl == pz && spans(px, b.x0, b.xl) && spans(py, b.y0, b.yl);
        default: m = b.y0 + b.yl == py && b.x0 == px && b.z0 == pz;
      endcase
      if (m) hit = i;
    end
    return hit;
  endfunction

  function automatic int unsigned umin(int unsigned a, int unsigned b);
    return a < b ? a : b;
  endfunction

  // Volume made unusable by one extreme point.
  function automatic logic [29:0] dead_volume(pev_pkg::spawn_t kind, int unsigned px,
      int unsigned py, int unsigned pz, int unsigned fw, int unsigned fh,
      int unsigned fd);
    int l, k, d;
    longint unsigned x, y, z;
    case (kind)
      pev_pkg::SPAWN_RIGHT: begin
        l = find_box(0, px, py, pz);
        k = find_box(3, px, py, pz);
        if (l < 0) return '0;
        z = boxes[l].zl;
        if (k >= 0) x = (boxes[k].x0 + boxes[k].xl - px) & 32'hffffffff;
        else if (pz == 0) x = fw;
        else return '0;
        y = (k >= 0) ? umin(boxes[k].yl, boxes[l].yl) : boxes[l].yl;
      end
      pev_pkg::SPAWN_TOP: begin
        d = find_box(4, px, py, pz);
        l = find_box(1, px, py, pz);
        k = find_box(3, px, py, pz);
        if (d < 0) return '0;
        if (k < 0 && pz > 0) return '0;
        if (l < 0 && px > 0) return '0;
        x = (k >= 0) ? umin(boxes[d].xl, boxes[k].x0 + boxes[k].xl - px) : boxes[d].xl;
        z = (l >= 0) ? umin(boxes[d].zl, boxes[l].z0 + boxes[l].zl - pz) : boxes[d].zl;
        if (k >= 0 && l >= 0)
          y = umin(boxes[k].y0 + boxes[k].yl - py, boxes[l].y0 + boxes[l].yl - py);
        else if (k >= 0) y = boxes[k].y0 + boxes[k].yl - py;
        else if (l >= 0) y = boxes[l].y0 + boxes[l].yl - py;
        else y = fh;
      end
      pev_pkg::SPAWN_FRONT: begin
        l = find_box(1, px, py, pz);
        k = find_box(2, px, py, pz);
        if (k < 0) return '0;
        x = boxes[k].xl;
        if (l >= 0) z = (boxes[l].z0 + boxes[l].zl - pz) & 32'hffffffff;
        else if (px == 0) z = fd;
        else return '0;
        y = (l >= 0) ? umin(boxes[k].yl, boxes[l].yl) : boxes[k].yl;
      end
      default: return '0;
    endcase
    return 30'(x * y * z);
  endfunction

  // Sends one beat, predicts its result and waits for acceptance.
  // Valid stays high after acceptance unless a gap or a drain follows.
  task automatic send_beat(pev_pkg::cmd_t cmd, int unsigned px, int unsigned py,
      int unsigned pz, int unsigned sx, int unsigned sy, int unsigned sz,
      pev_pkg::spawn_t kind, logic [29:0] cap);
    outcome_t e;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    // Fields are cut to their port widths as the block sees them.
    px = px & 1023; py = py & 1023; pz = pz & 1023;
    sx = sx & 1023; sy = sy & 1023; sz = sz & 1023;
    e.vol = '0;
    e.full = 1'b0;
    case (cmd)
      pev_pkg::CMD_CLEAR: box_total = 0;
      pev_pkg::CMD_ADD: begin
        if (box_total < BoxLimit) begin
          boxes[box_total] = '{px, py, pz, sx, sy, sz};
          box_total++;
        end else e.full = 1'b1;
      end
      pev_pkg::CMD_LOAD: free_cap = {2'b00, cap};
      default: begin
        e.vol = dead_volume(kind, px, py, pz, sx, sy, sz);
        free_cap = free_cap - 32'(e.vol);
      end
    endcase
    e.cap = free_cap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pos_x <= 10'(px); in_pos_y <= 10'(py); in_pos_z <= 10'(pz);
    in_size_x <= 10'(sx); in_size_y <= 10'(sy); in_size_z <= 10'(sz);
    in_spawn_kind <= kind;
    in_capacity_value <= cap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.push_back(e);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  function automatic pev_pkg::spawn_t any_kind();
    return pev_pkg::spawn_t'($urandom_range(0, 3));
  endfunction

  // Field extremes, every command and every spawn kind on touching boxes.
  task automatic test_directed();
    send_beat(pev_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, pev_pkg::SPAWN_NONE, 30'h3fffffff);
    send_beat(pev_pkg::CMD_POINT, 5, 5, 5, 1, 1, 1, pev_pkg::SPAWN_TOP, 0);
    send_beat(pev_pkg::CMD_ADD, 0, 0, 0, 10, 20, 30, pev_pkg::SPAWN_NONE, 0);
    send_beat(pev_pkg::CMD_ADD, 10, 0, 0, 5, 8, 7, pev_pkg::SPAWN_NONE, 0);
    send_beat(pev_pkg::CMD_ADD, 0, 0, 30, 12, 9, 4, pev_pkg::SPAWN_NONE, 0);
    send_beat(pev_pkg::CMD_ADD, 0, 20, 0, 6, 3, 11, pev_pkg::SPAWN_NONE, 0);
    send_beat(pev_pkg::CMD_POINT, 10, 0, 0, 100, 100, 100, pev_pkg::SPAWN_RIGHT, 0);
    send_beat(pev_pkg::CMD_POINT, 15, 0, 0, 40, 40, 40, pev_pkg::SPAWN_RIGHT, 0);
    send_beat(pev_pkg::CMD_POINT, 0, 0, 30, 50, 50, 50, pev_pkg::SPAWN_FRONT, 0);
    send_beat(pev_pkg::CMD_POINT, 0, 0, 34, 50, 50, 50, pev_pkg::SPAWN_FRONT, 0);
    send_beat(pev_pkg::CMD_POINT, 0, 20, 0, 50, 60, 50, pev_pkg::SPAWN_TOP, 0);
    send_beat(pev_pkg::CMD_POINT, 0, 23, 0, 50, 60, 50, pev_pkg::SPAWN_TOP, 0);
    send_beat(pev_pkg::CMD_POINT, 0, 20, 0, 0, 0, 0, pev_pkg::SPAWN_NONE, 0);
    send_beat(pev_pkg::CMD_ADD, 1023, 1023, 1023, 1023, 1023, 1023,
              pev_pkg::SPAWN_NONE, 0);
    send_beat(pev_pkg::CMD_POINT, 1023, 1023, 1023, 1023, 1023, 1023,
              pev_pkg::SPAWN_RIGHT, 0);
    send_beat(pev_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, pev_pkg::SPAWN_NONE, 30'd0);
    send_beat(pev_pkg::CMD_POINT, 10, 0, 0, 1023, 1023, 1023, pev_pkg::SPAWN_RIGHT,
              30'h3fffffff);
    send_beat(pev_pkg::CMD_CLEAR, 1023, 1023, 1023, 1023, 1023, 1023,
              pev_pkg::SPAWN_NONE, 0);
    send_beat(pev_pkg::CMD_POINT, 10, 0, 0, 100, 100, 100, pev_pkg::SPAWN_RIGHT, 0);
    wait_drained();
  endtask

  // Fills the table past its limit so that adds are dropped.
  task automatic test_full_table();
    for (int i = 0; i < BoxLimit + 3; i++)
      send_beat(pev_pkg::CMD_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023),
                pev_pkg::SPAWN_NONE, 0);
    send_beat(pev_pkg::CMD_POINT, boxes[63].x0 + boxes[63].xl, boxes[63].y0,
              boxes[63].z0, $urandom_range(0, 1023), 7, 9, pev_pkg::SPAWN_RIGHT, 0);
    send_beat(pev_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, pev_pkg::SPAWN_NONE, 0);
  endtask

  // Random stacks of small boxes with points on their faces, plus noise.
  task automatic test_random();
    int unsigned sent, b, base, x, y, z;
    pev_pkg::cmd_t c;
    sent = 0;
    while (sent < 1050) begin
      if ($urandom_range(0, 9) == 0) begin
        c = pev_pkg::cmd_t'($urandom_range(0, 3));
        send_beat(c, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023), any_kind(),
                  30'($urandom_range(0, 30'h3fffffff)));
        sent++;
        continue;
      end
      if (box_total > 40 || $urandom_range(0, 5) == 0) begin
        send_beat(pev_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, pev_pkg::SPAWN_NONE, 0);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_beat(pev_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, pev_pkg::SPAWN_NONE,
                  30'($urandom_range(0, 30'h3fffffff)));
        sent++;
      end
      base = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 1000);
      repeat ($urandom_range(1, 6)) begin
        x = $urandom_range(0, 3) == 0 ? 0 : base + $urandom_range(0, 12);
        y = $urandom_range(0, 3) == 0 ? 0 : base + $urandom_range(0, 12);
        z = $urandom_range(0, 3) == 0 ? 0 : base + $urandom_range(0, 12);
        send_beat(pev_pkg::CMD_ADD, x & 1023, y & 1023, z & 1023, $urandom_range(0, 9),
                  $urandom_range(0, 9), $urandom_range(0, 9), pev_pkg::SPAWN_NONE, 0);
        sent++;
      end
      repeat ($urandom_range(1, 6)) begin
        b = $urandom_range(0, box_total - 1);
        x = boxes[b].x0; y = boxes[b].y0; z = boxes[b].z0;
        case ($urandom_range(0, 3))
          0: x = x + boxes[b].xl;
          1: y = y + boxes[b].yl;
          2: z = z + boxes[b].zl;
          default: x = x + $urandom_range(0, 3);
        endcase
        send_beat(pev_pkg::CMD_POINT, x & 1023, y & 1023, z & 1023,
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), any_kind(), 0);
        sent++;
      end
      if (sent % 300 < 10) wait_drained();
    end
  endtask

  initial begin
    errors = 0;
    box_total = 0;
    free_cap = '0;
    burst_left = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    stall_mode = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random();
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
